// ===== sv/fpf_pkg.sv =====
// Shared types and constants for the Fibonacci prime factorizer.
package fpf_pkg;

  localparam int unsigned IDX_W       = 10;
  localparam int unsigned IDX_MAX     = 1023;
  localparam int unsigned VAL_W       = 31;
  localparam int unsigned DIV_W       = 16;
  localparam int unsigned SQ_W        = 32;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 64;
  localparam int unsigned DIV_STEPS   = VAL_W;
  localparam int unsigned DCNT_W      = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIB,
    ST_START,
    ST_CHECK,
    ST_DIV,
    ST_EMIT_FAC,
    ST_EMIT_REM,
    ST_EMIT_ZERO
  } state_t;

  typedef enum logic [1:0] {
    EMIT_FAC,
    EMIT_REM,
    EMIT_ZERO
  } emit_sel_t;

  typedef struct packed {
    logic      load;
    logic      fib_step;
    logic      fact_init;
    logic      div_start;
    logic      d_adv;
    logic      emit;
    emit_sel_t emit_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cnt_gt2;
    logic r_lt2;
    logic r_gt1;
    logic sq_gt_r;
    logic div_done;
    logic rem_zero;
    logic emit_ok;
  } dp_sts_t;

endpackage

// ===== sv/fibonacci_prime_factorizer_unit.sv =====
// Top level of the Fibonacci prime factorizer.
//
// Each input word carries an index n; the unit forms F(n) mod 2^31 (F1 = F2 = 1,
// index 0 gives 0, indexes above MAX_INDEX are clamped) and sends one output
// word per prime factor of that value in ascending order with repeats, tlast
// on the final one. A value of 0 or 1 yields a single word with factor 0.
// One index is in flight at a time; the next is accepted only after the final
// word of the previous one has been loaded into the output register. The
// recurrence does one add per cycle; trial division then tries 2, then odd
// divisors up to sqrt of the cofactor, every trial running through the
// shared bit-serial divider, and each emitted word waits for room in the
// output register.
module fibonacci_prime_factorizer_unit #(
  parameter int unsigned MAX_INDEX = 1023
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [fpf_pkg::IN_TDATA_W-1:0]      in_tdata,   // [9:0] index
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [fpf_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [30:0] fib_value, [61:31] factor
  output logic                                out_tlast
);

  fpf_pkg::ctrl_cmd_t cmd;
  fpf_pkg::dp_sts_t   sts;

  // sequence the work: recurrence, trial division, emission
  fpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // hold the terms, cofactor, divisor and the output word
  fpf_dp #(
    .MAX_INDEX (MAX_INDEX)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  // after taking an index the unit is not ready again in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on consecutive cycles");

  // a zero factor only ever stands alone as the final word
  a_zero_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[61:31] == '0) |-> out_tlast)
    else $error("zero factor on a non-final word");

  // every word that is not final carries a real factor
  a_factor_ge2: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> (out_tdata[61:31] >= 31'd2))
    else $error("non-final word with factor below two");

  // divisions start only from the trial check, never in the same cycle as an emit or a load
  a_div_start_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !cmd.emit && !cmd.load)
    else $error("divider started alongside another command");
`endif

endmodule

// ===== sv/fpf_div.sv =====
// Iterative restoring divider: one quotient bit per cycle.
module fpf_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [fpf_pkg::VAL_W-1:0]        dividend,
  input  logic [fpf_pkg::DIV_W-1:0]        divisor,
  output logic                             done,
  output logic [fpf_pkg::VAL_W-1:0]        quotient,
  output logic [fpf_pkg::DIV_W-1:0]        remainder
);

  localparam int unsigned VW = fpf_pkg::VAL_W;
  localparam int unsigned DW = fpf_pkg::DIV_W;
  localparam int unsigned CW = fpf_pkg::DCNT_W;
  localparam logic [CW-1:0] LAST_STEP = CW'(fpf_pkg::DIV_STEPS - 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [VW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW:0]   trial;
  logic          ge;

  assign trial = {rem_r, quo_r[VW-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // shift in the next dividend bit, subtract when it fits
      quo_nxt = {quo_r[VW-2:0], ge};
      rem_nxt = ge ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ===== sv/fpf_dp.sv =====
// Datapath: Fibonacci recurrence, trial divisor, cofactor and output register.
module fpf_dp #(
  parameter int unsigned MAX_INDEX = 1023
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [fpf_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  fpf_pkg::ctrl_cmd_t                  cmd,
  output fpf_pkg::dp_sts_t                    sts,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [fpf_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                out_tlast
);

  localparam int unsigned IW = fpf_pkg::IDX_W;
  localparam int unsigned VW = fpf_pkg::VAL_W;
  localparam int unsigned DW = fpf_pkg::DIV_W;
  localparam int unsigned SW = fpf_pkg::SQ_W;
  localparam int unsigned OW = fpf_pkg::OUT_TDATA_W;
  localparam int unsigned IDX_CAP =
    (MAX_INDEX > fpf_pkg::IDX_MAX) ? fpf_pkg::IDX_MAX : MAX_INDEX;
  localparam logic [IW-1:0] CAP = IW'(IDX_CAP);

  logic [IW-1:0] idx, n_sat;
  logic [IW-1:0] cnt_r;
  logic          zero_r;
  logic [VW-1:0] a_r, b_r, r_r, fib_r;
  logic [DW-1:0] d_r;
  logic [SW-1:0] sq_r;
  logic          out_valid_r;
  logic [VW-1:0] out_fib_r, out_fac_r;
  logic          out_last_r;
  logic          emit_ok;
  logic          div_done;
  logic [VW-1:0] div_quo;
  logic [DW-1:0] div_rem;
  logic [VW-1:0] fib_val;

  assign idx     = in_tdata[IW-1:0];
  assign n_sat   = (idx > CAP) ? CAP : idx;
  assign fib_val = zero_r ? '0 : b_r;
  assign emit_ok = !out_valid_r || out_tready;

  fpf_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (r_r),
    .divisor   (d_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cnt_r  <= n_sat;
      zero_r <= (n_sat == '0);
      a_r    <= VW'(1);
      b_r    <= VW'(1);
    end else if (cmd.fib_step) begin
      a_r   <= b_r;
      b_r   <= a_r + b_r;
      cnt_r <= cnt_r - 1'b1;
    end
    if (cmd.fact_init) begin
      fib_r <= fib_val;
      r_r   <= fib_val;
      d_r   <= DW'(2);
      sq_r  <= SW'(4);
    end else if (cmd.d_adv) begin
      // after 2 only odd divisors; keep the square in step
      if (d_r == DW'(2)) begin
        d_r  <= DW'(3);
        sq_r <= SW'(9);
      end else begin
        d_r  <= d_r + DW'(2);
        sq_r <= sq_r + {{(SW-DW-2){1'b0}}, d_r, 2'b00} + SW'(4);
      end
    end else if (cmd.emit && cmd.emit_sel == fpf_pkg::EMIT_FAC) begin
      r_r <= div_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_fib_r <= fib_r;
      case (cmd.emit_sel)
        fpf_pkg::EMIT_FAC: begin
          out_fac_r  <= VW'(d_r);
          out_last_r <= (div_quo == VW'(1));
        end
        fpf_pkg::EMIT_REM: begin
          out_fac_r  <= r_r;
          out_last_r <= 1'b1;
        end
        default: begin
          out_fac_r  <= '0;
          out_last_r <= 1'b1;
        end
      endcase
    end
  end

  assign sts.cnt_gt2  = cnt_r > IW'(2);
  assign sts.r_lt2    = r_r < VW'(2);
  assign sts.r_gt1    = r_r > VW'(1);
  assign sts.sq_gt_r  = sq_r > {1'b0, r_r};
  assign sts.div_done = div_done;
  assign sts.rem_zero = (div_rem == '0);
  assign sts.emit_ok  = emit_ok;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OW-2*VW){1'b0}}, out_fac_r, out_fib_r};
  assign out_tlast  = out_last_r;

endmodule

// ===== sv/fpf_ctrl.sv =====
// Controller: sequences the recurrence, the trial divisions and the word emission.
module fpf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  fpf_pkg::dp_sts_t   sts,
  output fpf_pkg::ctrl_cmd_t cmd
);

  fpf_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fpf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_tready    = 1'b0;
    cmd          = '0;
    cmd.emit_sel = fpf_pkg::EMIT_FAC;
    unique case (state_r)
      fpf_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = fpf_pkg::ST_FIB;
        end
      end
      fpf_pkg::ST_FIB: begin
        if (sts.cnt_gt2) begin
          cmd.fib_step = 1'b1;
        end else begin
          cmd.fact_init = 1'b1;
          state_nxt     = fpf_pkg::ST_START;
        end
      end
      fpf_pkg::ST_START: begin
        state_nxt = sts.r_lt2 ? fpf_pkg::ST_EMIT_ZERO : fpf_pkg::ST_CHECK;
      end
      fpf_pkg::ST_CHECK: begin
        if (sts.sq_gt_r) begin
          state_nxt = sts.r_gt1 ? fpf_pkg::ST_EMIT_REM : fpf_pkg::ST_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = fpf_pkg::ST_DIV;
        end
      end
      fpf_pkg::ST_DIV: begin
        if (sts.div_done) begin
          if (sts.rem_zero) begin
            state_nxt = fpf_pkg::ST_EMIT_FAC;
          end else begin
            cmd.d_adv = 1'b1;
            state_nxt = fpf_pkg::ST_CHECK;
          end
        end
      end
      fpf_pkg::ST_EMIT_FAC: begin
        if (sts.emit_ok) begin
          cmd.emit  = 1'b1;
          state_nxt = fpf_pkg::ST_CHECK;
        end
      end
      fpf_pkg::ST_EMIT_REM: begin
        cmd.emit_sel = fpf_pkg::EMIT_REM;
        if (sts.emit_ok) begin
          cmd.emit  = 1'b1;
          state_nxt = fpf_pkg::ST_IDLE;
        end
      end
      fpf_pkg::ST_EMIT_ZERO: begin
        cmd.emit_sel = fpf_pkg::EMIT_ZERO;
        if (sts.emit_ok) begin
          cmd.emit  = 1'b1;
          state_nxt = fpf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fpf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
